// ===== hw/rtl/hci_pkg.sv =====
// Shared constants and types for the Hermite cubic interpolator.
`default_nettype none

package hci_pkg;

  // Tension and bias are signed Q1.14
  localparam int COEF_FRAC = 14;
  localparam int CFG_W     = 16;
  localparam int COEF_W    = CFG_W + 1;
  localparam int COEF_ONE  = 1 << COEF_FRAC;

  // Extra bits of the tangent scale: 2^(2*COEF_FRAC+1)
  localparam int TAN_SHIFT = 2 * COEF_FRAC + 1;

  // Width of one partial-product slice of the wide multipliers
  localparam int SLICE_W = 32;

  // Configuration register index
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TENSION = 1'b0,
    CFG_BIAS    = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== hw/rtl/hci_tangent.sv =====
// Tangent and polynomial coefficient pipeline (five stages).
`default_nettype none

module hci_tangent #(
  parameter int SW = 16,
  parameter int FB = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire  logic signed [hci_pkg::CFG_W-1:0] tension_i,
  input  wire  logic signed [hci_pkg::CFG_W-1:0] bias_i,
  input  wire                                  valid_i,
  output logic                                 ready_o,
  input  wire  logic signed [SW-1:0]           y0_i,
  input  wire  logic signed [SW-1:0]           y1_i,
  input  wire  logic signed [SW-1:0]           y2_i,
  input  wire  logic signed [SW-1:0]           y3_i,
  input  wire  logic [FB-1:0]                  f_i,
  output logic                                 valid_o,
  input  wire                                  ready_i,
  output logic signed [SW+37:0]                c3_o,
  output logic signed [SW+37:0]                c2_o,
  output logic signed [SW+35:0]                m0_o,
  output logic signed [SW-1:0]                 y1_o,
  output logic [FB-1:0]                        f_o
);

  localparam int NS = 5;
  localparam int DW = SW + 1;
  localparam int PW = SW + 18;
  localparam int UW = SW + 19;
  localparam int MW = SW + 36;
  localparam int CW = SW + 38;
  localparam int KW = hci_pkg::COEF_W;
  localparam int TS = hci_pkg::TAN_SHIFT;

  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  logic signed [KW-1:0] p;
  logic signed [KW-1:0] q;
  logic signed [KW-1:0] d;

  // stage 1
  logic signed [DW-1:0] dy01_q, dy12_1_q, dy23_q;
  logic signed [SW-1:0] y1_1_q;
  logic [FB-1:0]        f_1_q;
  // stage 2
  logic signed [PW-1:0] pr0_q, qr0_q, pr1_q, qr1_q;
  logic signed [DW-1:0] dy12_2_q;
  logic signed [SW-1:0] y1_2_q;
  logic [FB-1:0]        f_2_q;
  // stage 3
  logic signed [UW-1:0] u0_q, u1_q;
  logic signed [DW-1:0] dy12_3_q;
  logic signed [SW-1:0] y1_3_q;
  logic [FB-1:0]        f_3_q;
  // stage 4
  logic signed [MW-1:0] m0_4_q, m1_q;
  logic signed [DW-1:0] dy12_4_q;
  logic signed [SW-1:0] y1_4_q;
  logic [FB-1:0]        f_4_q;
  // stage 5
  logic signed [CW-1:0] c3_q, c2_q;
  logic signed [MW-1:0] m0_5_q;
  logic signed [SW-1:0] y1_5_q;
  logic [FB-1:0]        f_5_q;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NS] = ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = ~v_q[s] | adv[s+1];
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Tangent weights: 1+b, 1-b, 1-t
  assign p = KW'(bias_i) + KW'(hci_pkg::COEF_ONE);
  assign q = KW'(hci_pkg::COEF_ONE) - KW'(bias_i);
  assign d = KW'(hci_pkg::COEF_ONE) - KW'(tension_i);

  // Stage 1: sample differences
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dy01_q   <= DW'(y1_i) - DW'(y0_i);
      dy12_1_q <= DW'(y2_i) - DW'(y1_i);
      dy23_q   <= DW'(y3_i) - DW'(y2_i);
      y1_1_q   <= y1_i;
      f_1_q    <= f_i;
    end
  end

  // Stage 2: bias-weighted differences
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      pr0_q    <= PW'(dy01_q) * PW'(p);
      qr0_q    <= PW'(dy12_1_q) * PW'(q);
      pr1_q    <= PW'(dy12_1_q) * PW'(p);
      qr1_q    <= PW'(dy23_q) * PW'(q);
      dy12_2_q <= dy12_1_q;
      y1_2_q   <= y1_1_q;
      f_2_q    <= f_1_q;
    end
  end

  // Stage 3: tangent numerators
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      u0_q     <= UW'(pr0_q) + UW'(qr0_q);
      u1_q     <= UW'(pr1_q) + UW'(qr1_q);
      dy12_3_q <= dy12_2_q;
      y1_3_q   <= y1_2_q;
      f_3_q    <= f_2_q;
    end
  end

  // Stage 4: apply tension
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      m0_4_q   <= MW'(u0_q) * MW'(d);
      m1_q     <= MW'(u1_q) * MW'(d);
      dy12_4_q <= dy12_3_q;
      y1_4_q   <= y1_3_q;
      f_4_q    <= f_3_q;
    end
  end

  // Stage 5: cubic and quadratic coefficients of the Horner form
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      c3_q   <= CW'(m0_4_q) + CW'(m1_q) - (CW'(dy12_4_q) <<< (TS + 1));
      c2_q   <= (CW'(dy12_4_q) <<< TS) + (CW'(dy12_4_q) <<< (TS + 1))
                - (CW'(m0_4_q) <<< 1) - CW'(m1_q);
      m0_5_q <= m0_4_q;
      y1_5_q <= y1_4_q;
      f_5_q  <= f_4_q;
    end
  end

  assign c3_o = c3_q;
  assign c2_o = c2_q;
  assign m0_o = m0_5_q;
  assign y1_o = y1_5_q;
  assign f_o  = f_5_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hci_mac.sv =====
// One Horner step: r * f + (addend << ASHIFT), sliced multiply over three stages.
`default_nettype none

module hci_mac #(
  parameter int AW     = 64,
  parameter int FB     = 16,
  parameter int ADDW   = 64,
  parameter int ASHIFT = 16,
  parameter int SBW    = 1,
  parameter int OW     = AW + FB + 1
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           valid_i,
  output logic                          ready_o,
  input  wire  logic signed [AW-1:0]    r_i,
  input  wire  logic [FB-1:0]           f_i,
  input  wire  logic signed [ADDW-1:0]  add_i,
  input  wire  logic [SBW-1:0]          side_i,
  output logic                          valid_o,
  input  wire                           ready_i,
  output logic signed [OW-1:0]          r_o,
  output logic [FB-1:0]                 f_o,
  output logic [SBW-1:0]                side_o
);

  localparam int NS  = 3;
  localparam int SL  = hci_pkg::SLICE_W;
  localparam int NC  = (AW + SL - 1) / SL;
  localparam int EW  = NC * SL;
  localparam int PPW = SL + FB + 2;

  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  logic signed [EW-1:0]  r_ext;
  logic signed [PPW-1:0] pp_d [NC];
  logic signed [OW-1:0]  sum_d;

  // stage A
  logic signed [PPW-1:0]  pp_q [NC];
  logic signed [ADDW-1:0] add_a_q;
  logic [FB-1:0]          f_a_q;
  logic [SBW-1:0]         side_a_q;
  // stage B
  logic signed [OW-1:0]   sum_q;
  logic signed [ADDW-1:0] add_b_q;
  logic [FB-1:0]          f_b_q;
  logic [SBW-1:0]         side_b_q;
  // stage C
  logic signed [OW-1:0]   r_q;
  logic [FB-1:0]          f_c_q;
  logic [SBW-1:0]         side_c_q;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NS] = ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = ~v_q[s] | adv[s+1];
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Slice r: lower slices unsigned, top slice signed
  assign r_ext = EW'(r_i);

  for (genvar j = 0; j < NC; j++) begin : g_slice
    logic signed [SL:0] slice;
    assign slice   = {((j == NC - 1) ? r_ext[SL*j+SL-1] : 1'b0), r_ext[SL*j +: SL]};
    assign pp_d[j] = PPW'(slice) * PPW'($signed({1'b0, f_i}));
  end

  // Stage A: partial products
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int j = 0; j < NC; j++) begin
        pp_q[j] <= pp_d[j];
      end
      add_a_q  <= add_i;
      f_a_q    <= f_i;
      side_a_q <= side_i;
    end
  end

  // Align and sum the partial products
  always_comb begin
    sum_d = '0;
    for (int j = 0; j < NC; j++) begin
      sum_d = sum_d + (OW'(pp_q[j]) <<< (SL * j));
    end
  end

  // Stage B: product
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sum_q    <= sum_d;
      add_b_q  <= add_a_q;
      f_b_q    <= f_a_q;
      side_b_q <= side_a_q;
    end
  end

  // Stage C: add the shifted lower-order coefficient
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      r_q      <= sum_q + (OW'(add_b_q) <<< ASHIFT);
      f_c_q    <= f_b_q;
      side_c_q <= side_b_q;
    end
  end

  assign r_o    = r_q;
  assign f_o    = f_c_q;
  assign side_o = side_c_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hci_round.sv =====
// Round to nearest, scale down and saturate; holds the output register.
`default_nettype none

module hci_round #(
  parameter int SW = 16,
  parameter int FB = 16,
  parameter int TW = 128
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  output logic                       ready_o,
  input  wire  logic signed [TW-1:0] t_i,
  output logic                       valid_o,
  input  wire                        ready_i,
  output logic [SW-1:0]              interp_o,
  output logic                       sat_o
);

  localparam int NS = 2;
  localparam int K  = 3 * FB + hci_pkg::TAN_SHIFT;

  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  logic signed [TW-1:0] t_q;
  logic [TW-K-SW:0]     hi;
  logic                 sat_d;
  logic [SW-1:0]        interp_d;
  logic [SW-1:0]        interp_q;
  logic                 sat_q;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NS] = ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = ~v_q[s] | adv[s+1];
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Stage 1: add one half of the final scale
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      t_q <= t_i + (TW'(1) <<< (K - 1));
    end
  end

  // Clip when the bits above the result are not all sign
  assign hi    = t_q[TW-1:K+SW-1];
  assign sat_d = ~(&hi | ~|hi);

  always_comb begin
    if (!sat_d) begin
      interp_d = t_q[K+SW-1:K];
    end else if (t_q[TW-1]) begin
      interp_d = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      interp_d = {1'b0, {(SW - 1){1'b1}}};
    end
  end

  // Stage 2: output register
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      interp_q <= interp_d;
      sat_q    <= sat_d;
    end
  end

  assign interp_o = interp_q;
  assign sat_o    = sat_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hermite_cubic_interpolator_core.sv =====
// Throughput: one transaction per cycle; each stage has its own valid bit and
// fills bubbles while the output stalls, so the input stays open until all are full.
// The pipeline is 5 tangent stages, three 3-stage Horner multiply-add steps, 2 round stages.
// Reset clears all valid bits and sets tension and bias to zero.
`default_nettype none

module hermite_cubic_interpolator_core #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration
  input  wire                                  cfg_we_i,
  input  wire  logic [hci_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  logic [hci_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input channel
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] sample_before_i,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] sample_start_i,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] sample_end_i,
  input  wire  logic signed [SAMPLE_WIDTH-1:0] sample_after_i,
  input  wire  logic [FRACTION_BITS-1:0]       fraction_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]       interpolated_o,
  output logic                                 saturated_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int MW  = SW + 36;
  localparam int CW  = SW + 38;
  localparam int R1W = CW + FB + 1;
  localparam int R2W = R1W + FB + 1;
  localparam int R3W = R2W + FB + 1;

  logic signed [hci_pkg::CFG_W-1:0] tension_q;
  logic signed [hci_pkg::CFG_W-1:0] bias_q;

  // tangent -> first step
  logic                 tan_valid, tan_ready;
  logic signed [CW-1:0] c3, c2;
  logic signed [MW-1:0] m0;
  logic signed [SW-1:0] y1;
  logic [FB-1:0]        f0;

  // first -> second step
  logic                  s1_valid, s1_ready;
  logic signed [R1W-1:0] r1;
  logic [FB-1:0]         f1;
  logic [MW+SW-1:0]      side1;

  // second -> third step
  logic                  s2_valid, s2_ready;
  logic signed [R2W-1:0] r2;
  logic [FB-1:0]         f2;
  logic [SW-1:0]         side2;

  // third step -> round
  logic                  s3_valid, s3_ready;
  logic signed [R3W-1:0] r3;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tension_q <= '0;
      bias_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (hci_pkg::cfg_reg_e'(cfg_idx_i))
        hci_pkg::CFG_TENSION: tension_q <= cfg_wdata_i;
        hci_pkg::CFG_BIAS:    bias_q    <= cfg_wdata_i;
        default:              ;
      endcase
    end
  end

  hci_tangent #(
    .SW (SW),
    .FB (FB)
  ) u_tangent (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tension_i (tension_q),
    .bias_i    (bias_q),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .y0_i      (sample_before_i),
    .y1_i      (sample_start_i),
    .y2_i      (sample_end_i),
    .y3_i      (sample_after_i),
    .f_i       (fraction_i),
    .valid_o   (tan_valid),
    .ready_i   (tan_ready),
    .c3_o      (c3),
    .c2_o      (c2),
    .m0_o      (m0),
    .y1_o      (y1),
    .f_o       (f0)
  );

  // r1 = c3 * f + c2 * N
  hci_mac #(
    .AW     (CW),
    .FB     (FB),
    .ADDW   (CW),
    .ASHIFT (FB),
    .SBW    (MW + SW),
    .OW     (R1W)
  ) u_mac1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tan_valid),
    .ready_o (tan_ready),
    .r_i     (c3),
    .f_i     (f0),
    .add_i   (c2),
    .side_i  ({m0, y1}),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .r_o     (r1),
    .f_o     (f1),
    .side_o  (side1)
  );

  // r2 = r1 * f + m0 * N^2
  hci_mac #(
    .AW     (R1W),
    .FB     (FB),
    .ADDW   (MW),
    .ASHIFT (2 * FB),
    .SBW    (SW),
    .OW     (R2W)
  ) u_mac2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .r_i     (r1),
    .f_i     (f1),
    .add_i   (side1[MW+SW-1:SW]),
    .side_i  (side1[SW-1:0]),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .r_o     (r2),
    .f_o     (f2),
    .side_o  (side2)
  );

  // r3 = r2 * f + y1 * N^3 * tangent scale
  hci_mac #(
    .AW     (R2W),
    .FB     (FB),
    .ADDW   (SW),
    .ASHIFT (3 * FB + hci_pkg::TAN_SHIFT),
    .SBW    (1),
    .OW     (R3W)
  ) u_mac3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .r_i     (r2),
    .f_i     (f2),
    .add_i   (side2),
    .side_i  (1'b0),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .r_o     (r3),
    .f_o     (),
    .side_o  ()
  );

  hci_round #(
    .SW (SW),
    .FB (FB),
    .TW (R3W)
  ) u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_valid),
    .ready_o  (s3_ready),
    .t_i      (r3),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .interp_o (interpolated_o),
    .sat_o    (saturated_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the Hermite cubic interpolator core.
`timescale 1ns / 100ps

module tb;

  localparam int SW             = 16;
  localparam int FB             = 16;
  localparam int ROUND_SHIFT    = 3 * FB + hci_pkg::TAN_SHIFT;
  localparam longint FRAC_ONE   = longint'(1) << FB;
  localparam longint SMAX       = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMIN       = -SMAX - 1;
  localparam int MAX_IDLE       = 17;
  localparam int LONG_HOLD      = 60;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 120;
  localparam int NUM_ROWS       = 16;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [159:0] wide_t;

  // One sample window and one interpolated result
  typedef struct packed {
    logic [SW-1:0] y0;
    logic [SW-1:0] y1;
    logic [SW-1:0] y2;
    logic [SW-1:0] y3;
    logic [FB-1:0] mu;
  } window_t;

  typedef struct packed {
    logic [SW-1:0] value;
    logic          sat;
  } interp_t;

  // Directed row: window plus an optional hand-computed result
  typedef struct packed {
    window_t win;
    logic    known;
    interp_t res;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [hci_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [hci_pkg::CFG_W-1:0]     cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [SW-1:0]                 sample_before_i;
  logic [SW-1:0]                 sample_start_i;
  logic [SW-1:0]                 sample_end_i;
  logic [SW-1:0]                 sample_after_i;
  logic [FB-1:0]                 fraction_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [SW-1:0]                 interpolated_o;
  logic                          saturated_o;

  hermite_cubic_interpolator_core #(
    .SAMPLE_WIDTH (SW),
    .FRACTION_BITS(FB)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_before_i(sample_before_i),
    .sample_start_i (sample_start_i),
    .sample_end_i   (sample_end_i),
    .sample_after_i (sample_after_i),
    .fraction_i     (fraction_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .interpolated_o (interpolated_o),
    .saturated_o    (saturated_o)
  );

  // Shadow copy of the tangent registers
  logic [hci_pkg::CFG_W-1:0] tension_q;
  logic [hci_pkg::CFG_W-1:0] bias_q;

  interp_t  expected_interp_q[$];
  int       err_count;
  bit       recv_no_idle;
  bit       long_hold_req;
  dir_row_t dir_rows [NUM_ROWS];

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Exact Hermite value with Kochanek-Bartels tangents, rounded half up, clipped
  function automatic interp_t hermite_predict(window_t w);
    longint y0, y1, y2, y3, f, g, p, q, d, u0, u1, h10, h01n, h11, v;
    wide_t  acc;
    interp_t r;
    y0   = longint'($signed(w.y0));
    y1   = longint'($signed(w.y1));
    y2   = longint'($signed(w.y2));
    y3   = longint'($signed(w.y3));
    f    = longint'(w.mu);
    g    = FRAC_ONE - f;
    p    = longint'(hci_pkg::COEF_ONE) + longint'($signed(bias_q));
    q    = longint'(hci_pkg::COEF_ONE) - longint'($signed(bias_q));
    d    = longint'(hci_pkg::COEF_ONE) - longint'($signed(tension_q));
    u0   = (y1 - y0) * p + (y2 - y1) * q;
    u1   = (y2 - y1) * p + (y3 - y2) * q;
    h10  = f * g * g;
    h01n = f * f * g;
    h11  = f * f * (3 * FRAC_ONE - 2 * f);
    acc  = (wide_t'(y1) <<< (3 * FB)) + wide_t'(h11) * wide_t'(y2 - y1);
    acc  = acc <<< hci_pkg::TAN_SHIFT;
    acc  = acc + (wide_t'(h10) * wide_t'(u0) - wide_t'(h01n) * wide_t'(u1)) * wide_t'(d);
    acc  = acc + (wide_t'(1) <<< (ROUND_SHIFT - 1));
    v    = longint'(acc >>> ROUND_SHIFT);
    r.sat = 1'b0;
    if (v > SMAX) begin
      v     = SMAX;
      r.sat = 1'b1;
    end else if (v < SMIN) begin
      v     = SMIN;
      r.sat = 1'b1;
    end
    r.value = v[SW-1:0];
    return r;
  endfunction

  function automatic logic [15:0] pick4(logic [15:0] a, logic [15:0] b,
                                        logic [15:0] c, logic [15:0] e);
    case ($urandom_range(0, 3))
      0:       return a;
      1:       return b;
      2:       return c;
      default: return e;
    endcase
  endfunction

  // Random window: mostly uniform, some smooth, corner and overshoot windows
  function automatic window_t random_window();
    window_t     w;
    int          kind;
    logic [15:0] base;
    logic [15:0] amp;
    kind = $urandom_range(0, 9);
    w.y0 = 16'($urandom);
    w.y1 = 16'($urandom);
    w.y2 = 16'($urandom);
    w.y3 = 16'($urandom);
    w.mu = 16'($urandom);
    if (kind == 5 || kind == 6) begin
      base = 16'($urandom);
      w.y0 = base;
      w.y1 = base + 16'($urandom_range(0, 1023)) - 16'd512;
      w.y2 = w.y1 + 16'($urandom_range(0, 1023)) - 16'd512;
      w.y3 = w.y2 + 16'($urandom_range(0, 1023)) - 16'd512;
    end else if (kind == 7) begin
      w.y0 = pick4(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
      w.y1 = pick4(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
      w.y2 = pick4(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
      w.y3 = pick4(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    end else if (kind == 8) begin
      w.mu = pick4(16'h0000, 16'h0001, 16'h8000, 16'hFFFF);
    end else if (kind == 9) begin
      amp = 16'($urandom_range(16384, 32767));
      if ($urandom_range(0, 1) == 1) amp = -amp;
      w.y0 = -amp;
      w.y1 = amp;
      w.y2 = amp;
      w.y3 = -amp;
    end
    return w;
  endfunction

  // Write one tangent register while the pipeline is empty
  task automatic write_reg(hci_pkg::cfg_reg_e idx, logic [hci_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == hci_pkg::CFG_TENSION) tension_q = data;
    else bias_q = data;
  endtask

  // Offer one window after a gap; queue its result once the transaction is taken
  task automatic send_window(window_t w, interp_t exp_res, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_before_i = w.y0;
    sample_start_i  = w.y1;
    sample_end_i    = w.y2;
    sample_after_i  = w.y3;
    fraction_i      = w.mu;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_interp_q = {expected_interp_q, exp_res};
  endtask

  // Drop valid and wait until every queued result has been seen
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_interp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic log_error(string what, interp_t want, interp_t got);
    if (err_count < MAX_REPORTS)
      $display("%s: want %0d sat %0b, got %0d sat %0b", what,
               $signed(want.value), want.sat, $signed(got.value), got.sat);
    err_count++;
  endtask

  // Compare one output transaction with the oldest queued result
  task automatic check_result();
    interp_t got;
    interp_t want;
    got.value = interpolated_o;
    got.sat   = saturated_o;
    if (expected_interp_q.size() == 0) begin
      want = '0;
      log_error("unexpected result", want, got);
    end else begin
      want = expected_interp_q.pop_front();
      if (got.value !== want.value || got.sat !== want.sat)
        log_error("mismatch", want, got);
    end
  endtask

  // Output side: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = recv_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result();
    end
  end

  // Watchdog: count cycles without any transaction
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // Main sequence: reset, directed windows, then random phases per register setting
  initial begin
    logic [hci_pkg::CFG_W-1:0] tension_set [NUM_PHASES];
    logic [hci_pkg::CFG_W-1:0] bias_set [NUM_PHASES];
    bit                        send_no_idle;
    window_t                   w;
    interp_t                   exp_res;
    int                        gap;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = hci_pkg::CFG_TENSION;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    sample_before_i = '0;
    sample_start_i  = '0;
    sample_end_i    = '0;
    sample_after_i  = '0;
    fraction_i      = '0;
    tension_q       = '0;
    bias_q          = '0;
    err_count       = 0;
    recv_no_idle    = 1'b0;
    long_hold_req   = 1'b0;
    send_no_idle    = 1'b0;

    // y0, y1, y2, y3, mu | known | value, sat (reset setting: no tension, no bias)
    dir_rows = '{
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0}},
      '{'{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000}, 1'b1, '{16'h7FFF, 1'b0}},
      '{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000}, 1'b1, '{16'h8000, 1'b0}},
      '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF}, 1'b1, '{16'h7FFF, 1'b0}},
      '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1, '{16'h8000, 1'b0}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA}, 1'b1, '{16'hFFFF, 1'b0}},
      // overshoot past either end clips
      '{'{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}, 1'b1, '{16'h7FFF, 1'b1}},
      '{'{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000}, 1'b1, '{16'h8000, 1'b1}},
      // exact halves round toward +infinity
      '{'{16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h8000}, 1'b1, '{16'h0001, 1'b0}},
      '{'{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000}, 1'b1, '{16'h0000, 1'b0}},
      '{'{16'h0064, 16'h00C8, 16'h012C, 16'h0190, 16'hFFFF}, 1'b0, '{16'h0000, 1'b0}},
      '{'{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0001}, 1'b0, '{16'h0000, 1'b0}},
      '{'{16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h4000}, 1'b0, '{16'h0000, 1'b0}},
      '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '{16'h0000, 1'b0}},
      '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '{16'h0000, 1'b0}},
      '{'{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hC000}, 1'b0, '{16'h0000, 1'b0}}
    };

    tension_set = '{16'h0000, 16'h4000, 16'hC000, 16'h0000, 16'h8000,
                    16'h7FFF, 16'h0000, 16'h0000, 16'h2000};
    bias_set    = '{16'h0000, 16'h0000, 16'h4000, 16'hC000, 16'h7FFF,
                    16'h8000, 16'h0000, 16'h0000, 16'hE000};
    tension_set[6] = 16'($urandom_range(0, 32768) - 16384);
    bias_set[6]    = 16'($urandom_range(0, 32768) - 16384);
    tension_set[7] = 16'($urandom);
    bias_set[7]    = 16'($urandom);

    // Hold reset, then release on a falling edge
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed windows at the reset setting
    for (int i = 0; i < NUM_ROWS; i++) begin
      w       = dir_rows[i].win;
      exp_res = dir_rows[i].known ? dir_rows[i].res : hermite_predict(w);
      send_window(w, exp_res, $urandom_range(0, MAX_IDLE));
    end
    drain_pipeline();

    // Random phases, one register setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(hci_pkg::CFG_TENSION, tension_set[ph]);
      write_reg(hci_pkg::CFG_BIAS, bias_set[ph]);
      send_no_idle = (ph == 2 || ph == 3);
      recv_no_idle = (ph == 3);
      if (ph == 2) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        w   = random_window();
        gap = send_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        send_window(w, hermite_predict(w), gap);
      end
      drain_pipeline();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_interp_q.size() != 0) begin
      $display("%0d results never arrived", expected_interp_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
